### hdl/motsl_pkg.sv
`default_nettype none

package motsl_pkg;

  localparam int VALUE_BITS    = 32;
  localparam int DEPTH_DEFAULT = 1024;

  typedef logic [1:0] cmd_t;

  localparam cmd_t CMD_APPEND_FIRST  = 2'd0;
  localparam cmd_t CMD_APPEND_SECOND = 2'd1;
  localparam cmd_t CMD_QUERY         = 2'd2;

  typedef struct packed {
    cmd_t                         cmd;
    logic signed [VALUE_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_BITS:0] median_doubled;
    logic                       empty_error;
    logic                       overflow_seen;
  } rsp_t;

endpackage

`default_nettype wire

### hdl/median_of_two_sorted_lists.sv
`default_nettype none

// Two ascending lists of signed values are loaded one value per transaction
// (cmd 0: first list, cmd 1: second list); during appends busy stays low, so
// they stream back to back. Appends beyond DEPTH are dropped and flagged in
// overflow_seen. cmd 2 returns twice the median on rsp for one cycle under
// done, then clears both lists; the receiver cannot stall, so the result must
// be taken in that cycle. A query with both lists empty answers with
// empty_error set. Otherwise a partition binary search runs over the shorter
// list: each search step passes through PROBE, FETCH and DECIDE (two reads of
// each list memory through its single read port, then a compare).

module median_of_two_sorted_lists #(
  parameter int DEPTH = motsl_pkg::DEPTH_DEFAULT
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire motsl_pkg::req_t req,
  output logic                 done,
  output motsl_pkg::rsp_t      rsp
);

  localparam int VB = motsl_pkg::VALUE_BITS;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int AW = DEPTH > 1 ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROBE  = 4'b0010,
    ST_FETCH  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_t;

  state_t          state;
  logic [CW-1:0]   count0, count1;
  logic            ovf;
  logic            swap;
  logic [CW-1:0]   m_len, n_len, half;
  logic            odd;
  logic [SW-1:0]   search_low, search_high;
  logic [SW-1:0]   idx_i, idx_j;
  logic [VB-1:0]   a_i, b_j1;

  logic            accept;
  logic            we0, we1;
  logic [AW-1:0]   raddr0, raddr1;
  logic [VB-1:0]   rdata0, rdata1;
  logic [AW-1:0]   a_addr, b_addr;
  logic [SW-1:0]   mid, j_calc;
  logic            empty;
  logic [CW-1:0]   m_next, n_next;
  logic [SW:0]     total;
  logic [VB-1:0]   a_rd, b_rd, a_i1, b_j;
  logic            go_up, go_down;
  logic [VB-1:0]   lo_v, hi_v;
  logic [VB:0]     sum;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign we0    = accept && (req.cmd == motsl_pkg::CMD_APPEND_FIRST) && (count0 != CW'(DEPTH));
  assign we1    = accept && (req.cmd == motsl_pkg::CMD_APPEND_SECOND) && (count1 != CW'(DEPTH));
  assign empty  = (count0 == '0) && (count1 == '0);

  always_comb begin
    m_next = (count0 > count1) ? count1 : count0;
    n_next = (count0 > count1) ? count0 : count1;
    total  = (SW + 1)'(m_next) + (SW + 1)'(n_next) + (SW + 1)'(1);
  end

  always_comb begin
    mid    = search_low + ((search_high - search_low) >> 1);
    j_calc = SW'(half) - mid;
    if (state == ST_PROBE) begin
      a_addr = mid[AW-1:0];
      b_addr = AW'(j_calc - SW'(1));
    end else begin
      a_addr = AW'(idx_i - SW'(1));
      b_addr = idx_j[AW-1:0];
    end
    raddr0 = swap ? b_addr : a_addr;
    raddr1 = swap ? a_addr : b_addr;
  end

  always_comb begin
    a_rd = swap ? rdata1 : rdata0;
    b_rd = swap ? rdata0 : rdata1;
    a_i1 = a_rd;
    b_j  = b_rd;
    go_up   = (idx_i < SW'(m_len)) && (idx_j != '0) && ($signed(b_j1) > $signed(a_i));
    go_down = (idx_i != '0) && (idx_j < SW'(n_len)) && ($signed(a_i1) > $signed(b_j));
    if (idx_i == '0) begin
      lo_v = b_j1;
    end else if (idx_j == '0) begin
      lo_v = a_i1;
    end else begin
      lo_v = ($signed(a_i1) > $signed(b_j1)) ? a_i1 : b_j1;
    end
    if (odd) begin
      hi_v = lo_v;
    end else if (idx_i == SW'(m_len)) begin
      hi_v = b_j;
    end else if (idx_j == SW'(n_len)) begin
      hi_v = a_i;
    end else begin
      hi_v = ($signed(a_i) > $signed(b_j)) ? b_j : a_i;
    end
    sum = {lo_v[VB-1], lo_v} + {hi_v[VB-1], hi_v};
  end

  motsl_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_first (
    .clk   (clk),
    .we    (we0),
    .waddr (count0[AW-1:0]),
    .wdata (req.value),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  motsl_ram #(.WIDTH(VB), .DEPTH(DEPTH)) u_second (
    .clk   (clk),
    .we    (we1),
    .waddr (count1[AW-1:0]),
    .wdata (req.value),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count0      <= '0;
      count1      <= '0;
      ovf         <= 1'b0;
      done        <= 1'b0;
      search_low  <= '0;
      search_high <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.cmd == motsl_pkg::CMD_APPEND_FIRST) begin
              if (we0) begin
                count0 <= count0 + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (req.cmd == motsl_pkg::CMD_APPEND_SECOND) begin
              if (we1) begin
                count1 <= count1 + CW'(1);
              end else begin
                ovf <= 1'b1;
              end
            end else if (req.cmd == motsl_pkg::CMD_QUERY) begin
              if (empty) begin
                done                <= 1'b1;
                rsp.median_doubled  <= '0;
                rsp.empty_error     <= 1'b1;
                rsp.overflow_seen   <= ovf;
                ovf                 <= 1'b0;
              end else begin
                swap        <= (count0 > count1);
                m_len       <= m_next;
                n_len       <= n_next;
                half        <= CW'(total >> 1);
                odd         <= total[0] == 1'b0;
                search_low  <= '0;
                search_high <= SW'(m_next);
                state       <= ST_PROBE;
              end
            end
          end
        end
        ST_PROBE: begin
          if (search_low > search_high) begin
            done               <= 1'b1;
            rsp.median_doubled <= '0;
            rsp.empty_error    <= 1'b0;
            rsp.overflow_seen  <= ovf;
            ovf                <= 1'b0;
            count0             <= '0;
            count1             <= '0;
            state              <= ST_IDLE;
          end else begin
            idx_i <= mid;
            idx_j <= j_calc;
            state <= ST_FETCH;
          end
        end
        ST_FETCH: begin
          a_i   <= a_rd;
          b_j1  <= b_rd;
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (go_up) begin
            search_low <= idx_i + SW'(1);
            state      <= ST_PROBE;
          end else if (go_down) begin
            search_high <= idx_i - SW'(1);
            state       <= ST_PROBE;
          end else begin
            done               <= 1'b1;
            rsp.median_doubled <= sum;
            rsp.empty_error    <= 1'b0;
            rsp.overflow_seen  <= ovf;
            ovf                <= 1'b0;
            count0             <= '0;
            count1             <= '0;
            state              <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/motsl_ram.sv
`default_nettype none

module motsl_ram #(
  parameter int WIDTH = motsl_pkg::VALUE_BITS,
  parameter int DEPTH = motsl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### bench/median_of_two_sorted_lists_tb.sv
`timescale 1ns / 100ps

module median_of_two_sorted_lists_tb;

  localparam int DEPTH         = motsl_pkg::DEPTH_DEFAULT;
  localparam int VALUE_BITS    = motsl_pkg::VALUE_BITS;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 100;
  localparam motsl_pkg::cmd_t CMD_UNUSED = 2'd3;

  localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef struct {
    motsl_pkg::req_t req;
    int              idle_pct;
    bit              drain_first;
  } pending_t;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  motsl_pkg::req_t req = '0;
  logic busy;
  logic done;
  motsl_pkg::rsp_t rsp;

  median_of_two_sorted_lists DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  pending_t        pending_requests[$];
  motsl_pkg::rsp_t expected_medians[$];

  // shadow of the two list memories
  logic signed [VALUE_BITS-1:0] first_vals  [DEPTH];
  logic signed [VALUE_BITS-1:0] second_vals [DEPTH];
  int first_len  = 0;
  int second_len = 0;
  bit dropped_since_query = 1'b0;

  int sender_idle_pct = 0;
  bit drain_next      = 1'b0;
  int queued_items    = 0;

  int appends_taken   = 0;
  int appends_dropped = 0;
  int queries_taken   = 0;
  int ignored_taken   = 0;
  int results_checked = 0;
  int mismatches      = 0;
  int idle_cycles     = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [VALUE_BITS-1:0] list_at(bit from_second, int idx);
    if (idx < 0 || idx >= DEPTH) return '0;
    return from_second ? second_vals[idx] : first_vals[idx];
  endfunction

  // partition search over the shorter list (first list on a tie)
  function automatic logic signed [VALUE_BITS:0] doubled_median();
    bit a_sec;
    int m, n, half, lo_i, hi_i, i, j;
    logic signed [VALUE_BITS-1:0] below, above;
    logic signed [VALUE_BITS:0] below_w, above_w;
    a_sec = first_len > second_len;
    m = a_sec ? second_len : first_len;
    n = a_sec ? first_len : second_len;
    half = (m + n + 1) / 2;
    lo_i = 0;
    hi_i = m;
    while (lo_i <= hi_i) begin
      i = lo_i + (hi_i - lo_i) / 2;
      j = half - i;
      if (i < m && j > 0 && list_at(!a_sec, j - 1) > list_at(a_sec, i)) begin
        lo_i = i + 1;
      end else if (i > 0 && j < n && list_at(a_sec, i - 1) > list_at(!a_sec, j)) begin
        hi_i = i - 1;
      end else begin
        if (i == 0)
          below = list_at(!a_sec, j - 1);
        else if (j == 0)
          below = list_at(a_sec, i - 1);
        else if (list_at(a_sec, i - 1) > list_at(!a_sec, j - 1))
          below = list_at(a_sec, i - 1);
        else
          below = list_at(!a_sec, j - 1);
        if ((m + n) % 2 == 1)
          above = below;
        else if (i == m)
          above = list_at(!a_sec, j);
        else if (j == n)
          above = list_at(a_sec, i);
        else if (list_at(a_sec, i) > list_at(!a_sec, j))
          above = list_at(!a_sec, j);
        else
          above = list_at(a_sec, i);
        below_w = below;
        above_w = above;
        return below_w + above_w;
      end
    end
    return '0;
  endfunction

  function automatic void predict_transaction(motsl_pkg::req_t t);
    motsl_pkg::rsp_t r;
    case (t.cmd)
      motsl_pkg::CMD_APPEND_FIRST: begin
        appends_taken++;
        if (first_len < DEPTH) begin
          first_vals[first_len] = t.value;
          first_len++;
        end else begin
          dropped_since_query = 1'b1;
          appends_dropped++;
        end
      end
      motsl_pkg::CMD_APPEND_SECOND: begin
        appends_taken++;
        if (second_len < DEPTH) begin
          second_vals[second_len] = t.value;
          second_len++;
        end else begin
          dropped_since_query = 1'b1;
          appends_dropped++;
        end
      end
      motsl_pkg::CMD_QUERY: begin
        queries_taken++;
        r.empty_error    = (first_len == 0 && second_len == 0);
        r.median_doubled = r.empty_error ? '0 : doubled_median();
        r.overflow_seen  = dropped_since_query;
        expected_medians.push_back(r);
        first_len  = 0;
        second_len = 0;
        dropped_since_query = 1'b0;
      end
      default: begin
        ignored_taken++;
      end
    endcase
  endfunction

  function automatic void queue_req(motsl_pkg::cmd_t c, logic signed [VALUE_BITS-1:0] v);
    pending_t p;
    p.req.cmd     = c;
    p.req.value   = v;
    p.idle_pct    = sender_idle_pct;
    p.drain_first = drain_next;
    drain_next    = 1'b0;
    pending_requests.push_back(p);
    if (c != CMD_UNUSED) queued_items++;
  endfunction

  function automatic int pick_value(int spread);
    if (spread == 0) return $urandom;
    if (spread == 1) return $urandom_range(20) - 10;
    case ($urandom_range(5))
      0: return VALUE_MAX;
      1: return VALUE_MIN;
      2: return VALUE_MAX - 1;
      3: return VALUE_MIN + 1;
      4: return -1;
      default: return 0;
    endcase
  endfunction

  function automatic int random_length();
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(6);
    if (roll < 95) return $urandom_range(24);
    return $urandom_range(100);
  endfunction

  // loads both lists, interleaving the two streams at random with occasional unused commands, then queries
  function automatic void queue_episode(int m, int n, bit ordered, int spread);
    int first_q[$];
    int second_q[$];
    int k;
    for (k = 0; k < m; k++) first_q.push_back(pick_value(spread));
    for (k = 0; k < n; k++) second_q.push_back(pick_value(spread));
    if (ordered) begin
      first_q.sort();
      second_q.sort();
    end
    while (first_q.size() + second_q.size() > 0) begin
      if ($urandom_range(99) < 3) queue_req(CMD_UNUSED, $urandom);
      if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(1) == 0))
        queue_req(motsl_pkg::CMD_APPEND_FIRST, first_q.pop_front());
      else
        queue_req(motsl_pkg::CMD_APPEND_SECOND, second_q.pop_front());
    end
    queue_req(motsl_pkg::CMD_QUERY, $urandom);
  endfunction

  function automatic void queue_random_phase(int item_count);
    int goal;
    goal = queued_items + item_count;
    while (queued_items < goal)
      queue_episode(random_length(), random_length(), $urandom_range(99) >= 10,
                    $urandom_range(2));
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_transaction(req);
      if (!start || !busy) begin
        if (pending_requests.size() != 0
            && !(pending_requests[0].drain_first && expected_medians.size() != 0)
            && $urandom_range(99) >= pending_requests[0].idle_pct) begin
          req   <= pending_requests[0].req;
          start <= 1'b1;
          void'(pending_requests.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    motsl_pkg::rsp_t want;
    if (!rst && done !== 1'b0) begin
      if (expected_medians.size() == 0) begin
        $display("%0t: unexpected result, expected none, got median_doubled %0d",
                 $time, rsp.median_doubled);
        mismatches++;
      end else begin
        want = expected_medians.pop_front();
        results_checked++;
        if (rsp.median_doubled !== want.median_doubled) begin
          $display("%0t: median_doubled expected %0d got %0d",
                   $time, want.median_doubled, rsp.median_doubled);
          mismatches++;
        end
        if (rsp.empty_error !== want.empty_error) begin
          $display("%0t: empty_error expected %b got %b",
                   $time, want.empty_error, rsp.empty_error);
          mismatches++;
        end
        if (rsp.overflow_seen !== want.overflow_seen) begin
          $display("%0t: overflow_seen expected %b got %b",
                   $time, want.overflow_seen, rsp.overflow_seen);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sender_idle_pct = 38;
    // both lists empty
    queue_req(motsl_pkg::CMD_QUERY, '1);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, VALUE_MAX);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, VALUE_MIN);
    queue_req(motsl_pkg::CMD_QUERY, '0);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, VALUE_MAX);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, VALUE_MAX);
    queue_req(motsl_pkg::CMD_QUERY, VALUE_MIN);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, VALUE_MIN);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, VALUE_MIN);
    queue_req(motsl_pkg::CMD_QUERY, VALUE_MAX);
    // unused selector, then empty again
    queue_req(CMD_UNUSED, 32'h5a5a_a5a5);
    queue_req(motsl_pkg::CMD_QUERY, '0);
    // first list empty, odd count
    queue_req(motsl_pkg::CMD_APPEND_SECOND, -5);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, 7);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, 100);
    queue_req(motsl_pkg::CMD_QUERY, '0);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, 1);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, 2);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, 3);
    queue_req(motsl_pkg::CMD_APPEND_SECOND, 4);
    queue_req(motsl_pkg::CMD_QUERY, '0);
    // descending list
    queue_req(motsl_pkg::CMD_APPEND_FIRST, 5);
    queue_req(motsl_pkg::CMD_APPEND_FIRST, 1);
    queue_req(motsl_pkg::CMD_QUERY, '0);

    queue_random_phase(130);
    sender_idle_pct = 76;
    drain_next = 1'b1;
    queue_random_phase(130);
    sender_idle_pct = 0;
    drain_next = 1'b1;
    // first list filled and pushed past DEPTH
    queue_episode(DEPTH + 2, 3, 1'b1, 0);
    queue_random_phase(90);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending_requests.size() != 0 || start) @(posedge clk);
    while (expected_medians.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d appends (%0d dropped on a full list), %0d median queries,",
             appends_taken, appends_dropped, queries_taken);
    $display("%0d unused commands; %0d results checked, %0d bad fields",
             ignored_taken, results_checked, mismatches);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
